FILE: sv/tile_histogram_equalizer_assert.svh
// Assertion macros for the tile histogram equaliser.
`ifndef TILE_HISTOGRAM_EQUALIZER_ASSERT_SVH
`define TILE_HISTOGRAM_EQUALIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define THE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define THE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("%m failed");
`else
`define THE_ASSERT(label, clk, rst_n, prop)
`define THE_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: sv/the_pkg.sv
// Shared types and constants of the tile histogram equaliser.
package the_pkg;
  localparam int unsigned NumBins   = 256;
  localparam int unsigned BinW      = 8;
  localparam int unsigned CountW    = 13;
  localparam int unsigned ValueW    = 16;
  localparam int unsigned PixelW    = 12;
  localparam logic [CountW-1:0] CountMax  = 13'd8191;
  localparam logic [ValueW-1:0] FullScale = 16'd65280;
  localparam int unsigned CumW = CountW + BinW;
  localparam int unsigned ProdW = CumW + ValueW;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StRead  = 8'b0000_0010,
    StWrite = 8'b0000_0100,
    StBRead = 8'b0000_1000,
    StBAcc  = 8'b0001_0000,
    StBMul  = 8'b0010_0000,
    StBDiv  = 8'b0100_0000,
    StClear = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic load;
    logic hist_rd;
    logic hist_wr;
    logic map_rd;
    logic out_strobe;
    logic clr_wr;
    logic bld_rd;
    logic bld_acc;
    logic bld_mul;
    logic div_start;
    logic tab_wr;
    logic idx_inc;
    logic idx_clr;
    logic cum_clr;
    logic set_ready;
    logic clr_ready;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic last;
    logic div_done;
    logic idx_end;
  } sts_t;
endpackage

FILE: sv/tile_histogram_equalizer.sv
// Top level of the tile histogram equaliser.
// Channel  | Ports                          | Handshake
// input    | op_i, pixel_i, last_i          | start_i high while busy_o low
// result   | enhanced_value_o               | valid_o high for one cycle
// Count and map words each pass through the idle, read and write states; a map result
// is registered in the write state and shows as the controller leaves it.
// A count word marked last adds the table build: 256 entries, each read, accumulated,
// scaled and divided by the bit-serial divider.
// A map word marked last adds a histogram clearing sweep over all 256 bins.
// Reset clears the pixel count and ready flag and starts the same clearing sweep
// with busy_o high; results cannot be stalled.
module tile_histogram_equalizer import the_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              op_i,
  input  logic [PixelW-1:0] pixel_i,
  input  logic              last_i,
  output logic              valid_o,
  output logic [ValueW-1:0] enhanced_value_o
);
  cmd_t cmd;
  sts_t sts;

  the_ctrl u_ctrl (.clk_i, .rst_ni, .start_i, .busy_o, .sts_i(sts), .cmd_o(cmd));
  the_datapath u_dp (
    .clk_i, .rst_ni, .op_i, .pixel_i, .last_i,
    .cmd_i(cmd), .sts_o(sts), .valid_o, .enhanced_value_o
  );
endmodule

FILE: sv/the_ctrl.sv
// Sequencing state machine of the tile histogram equaliser.
`include "tile_histogram_equalizer_assert.svh"
module the_ctrl import the_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StClear;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = StRead;
        end
      end
      StRead: begin
        if (sts_i.op) cmd_o.map_rd = 1'b1;
        else cmd_o.hist_rd = 1'b1;
        state_d = StWrite;
      end
      StWrite: begin
        if (sts_i.op) begin
          cmd_o.out_strobe = 1'b1;
          if (sts_i.last) begin
            cmd_o.idx_clr = 1'b1;
            cmd_o.clr_ready = 1'b1;
            state_d = StClear;
          end else state_d = StIdle;
        end else begin
          cmd_o.hist_wr = 1'b1;
          if (sts_i.last) begin
            cmd_o.idx_clr = 1'b1;
            cmd_o.cum_clr = 1'b1;
            state_d = StBRead;
          end else state_d = StIdle;
        end
      end
      StBRead: begin
        cmd_o.bld_rd = 1'b1;
        state_d = StBAcc;
      end
      StBAcc: begin
        cmd_o.bld_acc = 1'b1;
        state_d = StBMul;
      end
      StBMul: begin
        cmd_o.bld_mul = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d = StBDiv;
      end
      StBDiv: begin
        if (sts_i.div_done) begin
          cmd_o.tab_wr = 1'b1;
          cmd_o.idx_inc = 1'b1;
          if (sts_i.idx_end) begin
            cmd_o.set_ready = 1'b1;
            state_d = StIdle;
          end else state_d = StBRead;
        end
      end
      StClear: begin
        cmd_o.clr_wr = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.idx_end) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  `THE_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q))
  `THE_ASSERT_NEXT(a_load_busy, clk_i, rst_ni, cmd_o.load, busy_o)
  `THE_ASSERT(a_strobe_state, clk_i, rst_ni, !cmd_o.out_strobe || state_q == StWrite)
endmodule

FILE: sv/the_divider.sv
// Restoring divider, one quotient bit per cycle.
module the_divider import the_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] dividend_i,
  input  logic [CountW-1:0] divisor_i,
  output logic             done_o,
  output logic [ProdW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(ProdW + 1);
  logic [ProdW-1:0] quot_q, quot_d;
  logic [CountW:0]  rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d;
  logic [CountW:0]  trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign trial = {rem_q[CountW-1:0], quot_q[ProdW-1]};

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    quot_d = quot_q;
    rem_d = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CntW'(ProdW);
      quot_d = dividend_i;
      rem_d = '0;
    end else if (run_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial - {1'b0, divisor_i};
        quot_d = {quot_q[ProdW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[ProdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) run_d = 1'b0;
    end
  end

  assign done_o = run_q && (cnt_q == CntW'(1)) && !start_i ? 1'b0 : (!run_q && cnt_q == '0);
  assign quot_o = quot_q;
endmodule

FILE: sv/the_datapath.sv
// Histogram, map table and table build arithmetic.
module the_datapath import the_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_i,
  input  logic [PixelW-1:0] pixel_i,
  input  logic              last_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              valid_o,
  output logic [ValueW-1:0] enhanced_value_o
);
  logic [CountW-1:0] hist_mem [NumBins];
  logic [ValueW-1:0] map_mem [NumBins];
  logic              op_q, last_q, ready_q, valid_q, div_busy_q;
  logic [BinW-1:0]   level_q, idx_q;
  logic [CountW-1:0] rd_q, count_q;
  logic [ValueW-1:0] mrd_q;
  logic [CumW-1:0]   cum_q;
  logic [ProdW-1:0]  scaled, quot;
  logic              div_done;
  logic [BinW-1:0]   hist_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
      count_q <= '0;
      idx_q <= '0;
      valid_q <= 1'b0;
      div_busy_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.out_strobe;
      if (cmd_i.div_start) div_busy_q <= 1'b1;
      else if (div_done) div_busy_q <= 1'b0;
      if (cmd_i.set_ready) ready_q <= 1'b1;
      else if (cmd_i.clr_ready) ready_q <= 1'b0;
      if (cmd_i.clr_ready) count_q <= '0;
      else if (cmd_i.hist_wr && count_q != CountMax) count_q <= count_q + 1'b1;
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + 1'b1;
    end
  end

  assign hist_addr = cmd_i.hist_rd ? level_q : idx_q;

  // The full scale is 255 * 256, so the product is (cum << 16) - (cum << 8).
  assign scaled = {cum_q, {ValueW{1'b0}}} - ProdW'({cum_q, {BinW{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      last_q <= last_i;
      level_q <= (pixel_i > PixelW'(255)) ? BinW'(255) : pixel_i[BinW-1:0];
    end
    if (cmd_i.hist_rd || cmd_i.bld_rd) rd_q <= hist_mem[hist_addr];
    if (cmd_i.hist_wr) hist_mem[level_q] <= (rd_q == CountMax) ? rd_q : rd_q + 1'b1;
    if (cmd_i.clr_wr) hist_mem[idx_q] <= '0;
    if (cmd_i.map_rd) mrd_q <= map_mem[level_q];
    if (cmd_i.tab_wr)
      map_mem[idx_q] <= (quot > ProdW'(FullScale)) ? FullScale : quot[ValueW-1:0];
    if (cmd_i.cum_clr) cum_q <= '0;
    else if (cmd_i.bld_acc) cum_q <= cum_q + CumW'(rd_q);
    if (cmd_i.out_strobe) enhanced_value_o <= ready_q ? mrd_q : '0;
  end

  the_divider u_div (
    .clk_i, .rst_ni,
    .start_i   (cmd_i.bld_mul),
    .dividend_i(scaled),
    .divisor_i (count_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign sts_o.op = op_q;
  assign sts_o.last = last_q;
  assign sts_o.div_done = div_busy_q && div_done;
  assign sts_o.idx_end = (idx_q == BinW'(NumBins - 1));
  assign valid_o = valid_q;
endmodule

FILE: test/tb_tile_histogram_equalizer.sv
// Self-checking regression of the tile histogram equaliser with its own equalisation predictor.
`timescale 1ns / 1ps

module tb_tile_histogram_equalizer;
  import the_pkg::*;

  localparam int unsigned StallLimit = 100000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic              op_i = 1'b0;
  logic [PixelW-1:0] pixel_i = '0;
  logic              last_i = 1'b0;
  logic              valid_o;
  logic [ValueW-1:0] enhanced_value_o;

  logic [CountW-1:0] bin_tally [NumBins];
  logic [CountW-1:0] tile_pixels;
  logic [ValueW-1:0] cdf_table [NumBins];
  logic              cdf_ready;

  logic [ValueW-1:0] pending_values [$];
  int unsigned       mismatches = 0;
  int unsigned       quiet_cycles = 0;
  bit                gaps_on = 1'b1;
  int unsigned       words_sent = 0;

  always #2 clk_i = ~clk_i;

  tile_histogram_equalizer i_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .op_i,
    .pixel_i,
    .last_i,
    .valid_o,
    .enhanced_value_o
  );

  function automatic logic [CountW-1:0] bump(logic [CountW-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  function automatic void rebuild_cdf();
    logic [63:0] running;
    logic [63:0] scaled;
    running = '0;
    for (int i = 0; i < NumBins; i++) begin
      running += bin_tally[i];
      scaled = (tile_pixels == 0) ? 64'd0 : (running * FullScale) / tile_pixels;
      cdf_table[i] = (scaled > FullScale) ? FullScale : scaled[ValueW-1:0];
    end
    cdf_ready = 1'b1;
  endfunction

  function automatic void equalise_word(logic op, logic [PixelW-1:0] pix, logic fin);
    logic [BinW-1:0] level;
    level = (pix > 255) ? 8'd255 : pix[BinW-1:0];
    if (!op) begin
      bin_tally[level] = bump(bin_tally[level]);
      tile_pixels = bump(tile_pixels);
      if (fin) rebuild_cdf();
    end else begin
      pending_values.push_back(cdf_ready ? cdf_table[level] : '0);
      if (fin) begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
        tile_pixels = '0;
        cdf_ready = 1'b0;
      end
    end
  endfunction

  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PixelW-1:0] any_pixel();
    return ($urandom_range(0, 4) == 0) ? PixelW'($urandom_range(0, 4095))
                                       : PixelW'($urandom_range(0, 255));
  endfunction

  task automatic send_word(logic op, logic [PixelW-1:0] pix, logic fin);
    int unsigned gap;
    gap = gap_length();
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    op_i    <= op;
    pixel_i <= pix;
    last_i  <= fin;
    do @(posedge clk_i); while (busy_o);
    equalise_word(op, pix, fin);
    words_sent++;
  endtask

  task automatic count_tile(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_word(1'b0, any_pixel(), i == n - 1);
  endtask

  task automatic map_tile(int unsigned n, bit fin);
    for (int unsigned i = 0; i < n; i++) send_word(1'b1, any_pixel(), fin && i == n - 1);
  endtask

  always @(posedge clk_i) begin
    if (valid_o) begin
      if (pending_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: enhanced_value %0d", enhanced_value_o);
      end else begin
        logic [ValueW-1:0] want;
        want = pending_values.pop_front();
        if (enhanced_value_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("enhanced_value: expected %0d, got %0d", want, enhanced_value_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || valid_o || (start_i && !busy_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tile_histogram_equalizer regression: fail");
        $finish;
      end
    end
  end

  task automatic test_extremes();
    send_word(1'b1, 12'd0, 1'b1);
    send_word(1'b0, 12'd0, 1'b0);
    send_word(1'b0, 12'd255, 1'b0);
    send_word(1'b0, 12'd256, 1'b0);
    send_word(1'b0, 12'd4095, 1'b0);
    send_word(1'b0, 12'd2730, 1'b0);
    send_word(1'b0, 12'd1365, 1'b1);
    send_word(1'b1, 12'd0, 1'b0);
    send_word(1'b1, 12'd255, 1'b0);
    send_word(1'b1, 12'd4095, 1'b0);
    send_word(1'b1, 12'd85, 1'b0);
    send_word(1'b1, 12'd170, 1'b1);
    send_word(1'b0, 12'd7, 1'b1);
    send_word(1'b1, 12'd6, 1'b0);
    send_word(1'b1, 12'd7, 1'b1);
  endtask

  task automatic test_map_before_ready();
    send_word(1'b1, 12'd42, 1'b0);
    send_word(1'b1, 12'd4095, 1'b1);
    send_word(1'b0, 12'd3, 1'b0);
    send_word(1'b1, 12'd3, 1'b1);
    send_word(1'b1, 12'd3, 1'b1);
  endtask

  task automatic test_count_while_ready();
    send_word(1'b0, 12'd10, 1'b0);
    send_word(1'b0, 12'd200, 1'b1);
    send_word(1'b0, 12'd50, 1'b0);
    send_word(1'b1, 12'd100, 1'b0);
    send_word(1'b0, 12'd20, 1'b1);
    send_word(1'b1, 12'd100, 1'b0);
    send_word(1'b1, 12'd15, 1'b1);
  endtask

  task automatic test_saturation();
    gaps_on = 1'b0;
    for (int i = 0; i < 8300; i++) send_word(1'b0, 12'd0, 1'b0);
    for (int i = 0; i < 100; i++) send_word(1'b0, 12'd9, 1'b0);
    send_word(1'b0, 12'd4000, 1'b1);
    gaps_on = 1'b1;
    send_word(1'b1, 12'd0, 1'b0);
    send_word(1'b1, 12'd9, 1'b0);
    send_word(1'b1, 12'd255, 1'b1);
  endtask

  task automatic test_random_tiles();
    int unsigned kind;
    int unsigned start_count;
    start_count = words_sent;
    while (words_sent - start_count < 900) begin
      kind = $urandom_range(0, 9);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (kind < 6) begin
        count_tile(($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40));
        map_tile($urandom_range(1, 40), 1'b1);
      end else if (kind == 6) begin
        map_tile($urandom_range(1, 5), 1'b1);
      end else if (kind == 7) begin
        count_tile($urandom_range(1, 20));
        map_tile($urandom_range(1, 10), 1'b0);
        send_word(1'b0, any_pixel(), 1'b0);
        map_tile($urandom_range(1, 10), 1'b1);
      end else if (kind == 8) begin
        count_tile($urandom_range(1, 20));
        count_tile($urandom_range(1, 20));
        map_tile($urandom_range(1, 20), 1'b1);
      end else begin
        for (int i = 0; i < 6; i++) send_word($urandom_range(0, 1), any_pixel(), 1'b0);
        map_tile(1, 1'b1);
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    foreach (bin_tally[i]) bin_tally[i] = '0;
    foreach (cdf_table[i]) cdf_table[i] = '0;
    tile_pixels = '0;
    cdf_ready = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_map_before_ready();
    test_count_while_ready();
    test_saturation();
    test_random_tiles();
    @(negedge clk_i);
    start_i <= 1'b0;
    wait (pending_values.size() == 0);
    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && pending_values.size() == 0) begin
      $display("tile_histogram_equalizer regression: pass");
    end else begin
      $display("tile_histogram_equalizer regression: fail");
    end
    $finish;
  end
endmodule
